// File: design/ptsea_pkg.sv
`default_nettype none
package ptsea_pkg;

	// Field widths of the request and result ports
	localparam int CMD_W   = 3;
	localparam int TID_W   = 32;
	localparam int NUM_W   = 12;
	localparam int SAMPLE_W = 48;
	localparam int STAT_W  = 2;
	localparam int TOUCH_W = 10;
	localparam int TOTAL_W = 64;
	localparam int COUNT_W = 48;

	// Widest slot index and syscall number carried between modules
	localparam int SLOT_MAX_W = 10;
	localparam int CALL_MAX_W = 12;

	// Commands
	localparam logic [CMD_W-1:0] CMD_ENTER  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_EXIT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SWOUT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SWIN   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

	// Thread entry flags
	localparam int FLAG_W = 3;
	localparam logic [FLAG_W-1:0] FL_VALID   = 3'b001;
	localparam logic [FLAG_W-1:0] FL_INCALL  = 3'b010;
	localparam logic [FLAG_W-1:0] FL_RUNNING = 3'b100;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic                  hit;
		logic                  full;
		logic [SLOT_MAX_W-1:0] slot;
		logic [FLAG_W-1:0]     flags;
		logic [CALL_MAX_W-1:0] call;
	} lookup_t;

	typedef struct packed {
		logic                  we;
		logic [SLOT_MAX_W-1:0] slot;
		logic [TID_W-1:0]      tag;
		logic [FLAG_W-1:0]     flags;
		logic [CALL_MAX_W-1:0] call;
	} tt_update_t;

endpackage
`default_nettype wire

// File: design/ptsea_ram.sv
`default_nettype none
module ptsea_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/ptsea_thread_table.sv
`default_nettype none
module ptsea_thread_table #(
	parameter int THREAD_SLOTS = 64,
	parameter int CALL_W = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [ptsea_pkg::TID_W-1:0]   tid,
	output ptsea_pkg::lookup_t                 lk,
	input  wire ptsea_pkg::tt_update_t         upd
);
	localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

	logic [ptsea_pkg::TID_W-1:0]  tag_q   [THREAD_SLOTS];
	logic [ptsea_pkg::FLAG_W-1:0] flags_q [THREAD_SLOTS];
	logic [CALL_W-1:0]            call_q  [THREAD_SLOTS];

	logic          hit;
	logic          free_any;
	logic [SW-1:0] hit_idx;
	logic [SW-1:0] free_idx;
	logic [SW-1:0] sel;

	// Match the tag and find the lowest free slot; lowest index wins
	always_comb begin
		hit = 1'b0;
		free_any = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
			if (flags_q[i][0] && tag_q[i] == tid) begin
				hit = 1'b1;
				hit_idx = SW'(i);
			end
			if (!flags_q[i][0]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
		sel = hit ? hit_idx : free_idx;
		lk.hit = hit;
		lk.full = !hit && !free_any;
		lk.slot = ptsea_pkg::SLOT_MAX_W'(sel);
		lk.flags = hit ? flags_q[hit_idx] : '0;
		lk.call = hit ? ptsea_pkg::CALL_MAX_W'(call_q[hit_idx]) : '0;
	end

	// Write back one entry per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				tag_q[i] <= '0;
				flags_q[i] <= '0;
				call_q[i] <= '0;
			end
		end else if (upd.we) begin
			tag_q[upd.slot[SW-1:0]] <= upd.tag;
			flags_q[upd.slot[SW-1:0]] <= upd.flags;
			call_q[upd.slot[SW-1:0]] <= upd.call[CALL_W-1:0];
		end
	end
endmodule
`default_nettype wire

// File: design/per_thread_syscall_energy_accumulator.sv
`default_nettype none
// Per-thread syscall energy accumulator.
// Request channel: command, thread_id, call_number and energy_sample are taken
// at a rising edge where start is high and busy is low. Commands are enter,
// exit, switch out, switch in and read totals.
// Result channel: done is high for exactly one cycle with status,
// touched_call, energy_total and call_count; the receiver cannot stall it.
// Flow: the request is registered, then a tag match and memory read state
// and an update and write-back state follow, and done is registered from the
// latter; busy is high in both states, so no new request is taken while the
// per-syscall totals memories are being read, modified and written back.
// A new request can be taken at the edge that ends its predecessor's result.
// Reset: the thread table clears at once, then a clearing pass writes zero to
// every totals and counts entry with busy high.
// Energy deltas are taken modulo 2^ENERGY_BITS; totals saturate at 2^64-1 and
// completion counts at 2^48-1.
module per_thread_syscall_energy_accumulator #(
	parameter int THREAD_SLOTS = 64,
	parameter int CALL_SLOTS = 1024,
	parameter int ENERGY_BITS = 48
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [ptsea_pkg::CMD_W-1:0]       command,
	input  wire logic [ptsea_pkg::TID_W-1:0]       thread_id,
	input  wire logic [ptsea_pkg::NUM_W-1:0]       call_number,
	input  wire logic [ptsea_pkg::SAMPLE_W-1:0]    energy_sample,
	output logic                                   done,
	output logic [ptsea_pkg::STAT_W-1:0]           status,
	output logic [ptsea_pkg::TOUCH_W-1:0]          touched_call,
	output logic [ptsea_pkg::TOTAL_W-1:0]          energy_total,
	output logic [ptsea_pkg::COUNT_W-1:0]          call_count
);
	localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
	localparam int CW = $clog2(CALL_SLOTS);
	localparam int EW = ENERGY_BITS;
	localparam logic [CW-1:0] CLR_LAST = CW'(CALL_SLOTS - 1);
	localparam logic [ptsea_pkg::NUM_W:0] NUM_LIMIT = (ptsea_pkg::NUM_W + 1)'(CALL_SLOTS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_CLR  = 2'd3;

	logic [1:0]  state_q;
	logic [CW-1:0] clr_q;

	logic [ptsea_pkg::CMD_W-1:0]  cmd_q;
	logic [ptsea_pkg::TID_W-1:0]  tid_q;
	logic [ptsea_pkg::NUM_W-1:0]  num_q;
	logic [EW-1:0]                now_q;

	ptsea_pkg::lookup_t    lk;
	ptsea_pkg::tt_update_t tt_upd;

	logic                          hit_s1;
	logic                          full_s1;
	logic [SW-1:0]                 slot_s1;
	logic [ptsea_pkg::FLAG_W-1:0]  flags_s1;
	logic [CW-1:0]                 addr_s1;

	logic [CW-1:0]  rd_addr;
	logic [EW-1:0]  start_rd;
	logic [ptsea_pkg::TOTAL_W-1:0] tot_rd;
	logic [ptsea_pkg::COUNT_W-1:0] cnt_rd;

	logic num_ok;
	logic [EW-1:0] delta;
	logic [ptsea_pkg::TOTAL_W:0] sum;
	logic [ptsea_pkg::TOTAL_W-1:0] tot_sat;
	logic [ptsea_pkg::COUNT_W-1:0] cnt_inc;

	logic upd_now;
	logic tot_we;
	logic cnt_we;
	logic st_we;
	logic [ptsea_pkg::STAT_W-1:0]  stat_n;
	logic [ptsea_pkg::TOTAL_W-1:0] tot_n;
	logic [ptsea_pkg::COUNT_W-1:0] cnt_n;
	logic [ptsea_pkg::FLAG_W-1:0]  flags_n;
	logic [CW-1:0]                 call_n;
	logic [ptsea_pkg::FLAG_W-1:0]  flags_b;
	logic run;
	logic incall;
	logic [ptsea_pkg::CALL_MAX_W-1:0] touch_wide;

	logic               mem_we_t;
	logic               mem_we_c;
	logic [CW-1:0]      mem_waddr;
	logic [ptsea_pkg::TOTAL_W-1:0] tot_wdata;
	logic [ptsea_pkg::COUNT_W-1:0] cnt_wdata;

	assign busy = (state_q != S_IDLE);
	assign upd_now = (state_q == S_UPD);

	ptsea_thread_table #(
		.THREAD_SLOTS(THREAD_SLOTS),
		.CALL_W(CW)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.tid(tid_q),
		.lk(lk),
		.upd(tt_upd)
	);

	// Read address: the named syscall for enter and read, else the entry's syscall
	always_comb begin
		if (cmd_q == ptsea_pkg::CMD_ENTER || cmd_q == ptsea_pkg::CMD_READ) begin
			rd_addr = num_q[CW-1:0];
		end else begin
			rd_addr = lk.call[CW-1:0];
		end
	end

	ptsea_ram #(.WIDTH(EW), .DEPTH(THREAD_SLOTS)) u_start_ram (
		.clk(clk),
		.we(st_we && upd_now),
		.waddr(slot_s1),
		.wdata(now_q),
		.raddr(lk.slot[SW-1:0]),
		.rdata(start_rd)
	);

	ptsea_ram #(.WIDTH(ptsea_pkg::TOTAL_W), .DEPTH(CALL_SLOTS)) u_total_ram (
		.clk(clk),
		.we(mem_we_t),
		.waddr(mem_waddr),
		.wdata(tot_wdata),
		.raddr(rd_addr),
		.rdata(tot_rd)
	);

	ptsea_ram #(.WIDTH(ptsea_pkg::COUNT_W), .DEPTH(CALL_SLOTS)) u_count_ram (
		.clk(clk),
		.we(mem_we_c),
		.waddr(mem_waddr),
		.wdata(cnt_wdata),
		.raddr(rd_addr),
		.rdata(cnt_rd)
	);

	// Clearing pass writes zero, otherwise write back the update
	always_comb begin
		if (state_q == S_CLR) begin
			mem_we_t = 1'b1;
			mem_we_c = 1'b1;
			mem_waddr = clr_q;
			tot_wdata = '0;
			cnt_wdata = '0;
		end else begin
			mem_we_t = upd_now && tot_we;
			mem_we_c = upd_now && cnt_we;
			mem_waddr = addr_s1;
			tot_wdata = tot_sat;
			cnt_wdata = cnt_inc;
		end
	end

	// Segment arithmetic
	always_comb begin
		num_ok = ({1'b0, num_q} < NUM_LIMIT);
		delta = now_q - start_rd;
		sum = {1'b0, tot_rd} + (ptsea_pkg::TOTAL_W + 1)'(delta);
		tot_sat = sum[ptsea_pkg::TOTAL_W] ? {ptsea_pkg::TOTAL_W{1'b1}}
			: sum[ptsea_pkg::TOTAL_W-1:0];
		cnt_inc = (cnt_rd == ptsea_pkg::COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
	end

	// Decide the update and the result for the request
	always_comb begin
		stat_n = ptsea_pkg::ST_IGNORED;
		tot_n = tot_rd;
		cnt_n = cnt_rd;
		tot_we = 1'b0;
		cnt_we = 1'b0;
		st_we = 1'b0;
		flags_b = hit_s1 ? flags_s1 : ptsea_pkg::FL_VALID;
		flags_n = flags_b;
		call_n = addr_s1;
		incall = |(flags_b & ptsea_pkg::FL_INCALL);
		run = incall && |(flags_b & ptsea_pkg::FL_RUNNING);
		tt_upd.we = 1'b0;
		unique case (cmd_q) inside
			ptsea_pkg::CMD_READ: begin
				stat_n = num_ok ? ptsea_pkg::ST_DONE : ptsea_pkg::ST_RANGE;
			end
			ptsea_pkg::CMD_EXIT: begin
				if (hit_s1) begin
					stat_n = ptsea_pkg::ST_DONE;
					tot_we = run;
					cnt_we = incall;
					tot_n = run ? tot_sat : tot_rd;
					cnt_n = incall ? cnt_inc : cnt_rd;
					flags_n = '0;
					call_n = '0;
					tt_upd.we = 1'b1;
				end
			end
			ptsea_pkg::CMD_ENTER, ptsea_pkg::CMD_SWOUT, ptsea_pkg::CMD_SWIN: begin
				if (full_s1) begin
					stat_n = ptsea_pkg::ST_FULL;
				end else begin
					tt_upd.we = 1'b1;
					stat_n = ptsea_pkg::ST_DONE;
					if (cmd_q == ptsea_pkg::CMD_ENTER) begin
						if (!num_ok) begin
							stat_n = ptsea_pkg::ST_RANGE;
							flags_n = ptsea_pkg::FL_VALID;
							call_n = '0;
						end else begin
							st_we = 1'b1;
							flags_n = ptsea_pkg::FL_VALID | ptsea_pkg::FL_INCALL
								| ptsea_pkg::FL_RUNNING;
						end
					end else if (cmd_q == ptsea_pkg::CMD_SWOUT) begin
						if (run) begin
							tot_we = 1'b1;
							tot_n = tot_sat;
							flags_n = flags_b & ~ptsea_pkg::FL_RUNNING;
						end
					end else begin
						if (incall && !run) begin
							st_we = 1'b1;
							flags_n = flags_b | ptsea_pkg::FL_RUNNING;
						end
					end
				end
			end
			default: begin
				stat_n = ptsea_pkg::ST_IGNORED;
			end
		endcase
		tt_upd.we = tt_upd.we && upd_now;
		tt_upd.slot = ptsea_pkg::SLOT_MAX_W'(slot_s1);
		tt_upd.tag = tid_q;
		tt_upd.flags = flags_n;
		tt_upd.call = ptsea_pkg::CALL_MAX_W'(call_n);
		touch_wide = ptsea_pkg::CALL_MAX_W'(addr_s1);
	end

	// Sequence: clear after reset, then take, look up, update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			done <= 1'b0;
		end else begin
			done <= upd_now;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the request and the lookup result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= command;
			tid_q <= thread_id;
			num_q <= call_number;
			now_q <= EW'(energy_sample);
		end
		if (state_q == S_LOOK) begin
			hit_s1 <= lk.hit;
			full_s1 <= lk.full;
			slot_s1 <= lk.slot[SW-1:0];
			flags_s1 <= lk.flags;
			addr_s1 <= rd_addr;
		end
		if (upd_now) begin
			status <= stat_n;
			if (stat_n == ptsea_pkg::ST_DONE) begin
				touched_call <= touch_wide[ptsea_pkg::TOUCH_W-1:0];
				energy_total <= tot_n;
				call_count <= cnt_n;
			end else begin
				touched_call <= '0;
				energy_total <= '0;
				call_count <= '0;
			end
		end
	end

	// Checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request taken without going busy");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ptsea_pkg::ST_DONE) |->
		(energy_total == '0 && call_count == '0 && touched_call == '0))
		else $error("nonzero fields on a non-done result");

	a_result_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |=> done) else $error("update without result");
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ptsea_pkg::*;

	typedef struct {
		logic [STAT_W-1:0]  st;
		logic [TOUCH_W-1:0] call;
		logic [TOTAL_W-1:0] total;
		logic [COUNT_W-1:0] count;
	} energy_report_t;

	localparam int SLOTS = 64;
	localparam int CALLS = 1024;

	// Thread table and per-syscall totals mirror, with the queue of pending reports
	class energy_scoreboard;
		logic [TID_W-1:0]    tid_tab [SLOTS];
		logic [FLAG_W-1:0]   flag_tab [SLOTS];
		logic [NUM_W-1:0]    call_tab [SLOTS];
		logic [SAMPLE_W-1:0] seg_start [SLOTS];
		logic [TOTAL_W-1:0]  totals [CALLS];
		logic [COUNT_W-1:0]  counts [CALLS];
		energy_report_t      pending [$];
		int                  mismatches;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				tid_tab[i] = '0;
				flag_tab[i] = '0;
				call_tab[i] = '0;
				seg_start[i] = '0;
			end
			for (int i = 0; i < CALLS; i++) begin
				totals[i] = '0;
				counts[i] = '0;
			end
			mismatches = 0;
		endfunction

		function void fill_report(ref energy_report_t r, input logic [NUM_W-1:0] c);
			r.st = ST_DONE;
			r.call = c[TOUCH_W-1:0];
			r.total = totals[c];
			r.count = counts[c];
		endfunction

		// Add the elapsed energy of the open segment and stop it
		function void close_seg(int s, logic [SAMPLE_W-1:0] now);
			logic [SAMPLE_W-1:0] delta;
			logic [TOTAL_W:0] sum;
			delta = now - seg_start[s];
			sum = {1'b0, totals[call_tab[s]]} + delta;
			totals[call_tab[s]] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
			flag_tab[s] &= ~FL_RUNNING;
		endfunction

		// Predict the report for an accepted request
		function void note(logic [CMD_W-1:0] cmd, logic [TID_W-1:0] tid,
				logic [NUM_W-1:0] num, logic [SAMPLE_W-1:0] now);
			energy_report_t r;
			int s;
			logic [NUM_W-1:0] c;
			logic ic, run;
			r = '{ST_IGNORED, '0, '0, '0};
			s = -1;
			if (cmd == CMD_READ) begin
				if (num >= CALLS) r.st = ST_RANGE;
				else fill_report(r, num);
			end else if (cmd < CMD_READ) begin
				for (int i = 0; i < SLOTS; i++)
					if (s < 0 && (flag_tab[i] & FL_VALID) && tid_tab[i] == tid) s = i;
				if (cmd == CMD_EXIT) begin
					if (s >= 0) begin
						c = call_tab[s];
						ic = (flag_tab[s] & FL_INCALL) != 0;
						run = (flag_tab[s] & FL_RUNNING) != 0;
						if (ic && run) close_seg(s, now);
						if (ic && counts[c] != COUNT_MAX) counts[c]++;
						flag_tab[s] = '0;
						call_tab[s] = '0;
						fill_report(r, c);
					end
				end else begin
					// Take the lowest free slot for an unknown thread
					if (s < 0)
						for (int i = 0; i < SLOTS; i++)
							if (s < 0 && !(flag_tab[i] & FL_VALID)) begin
								s = i;
								tid_tab[i] = tid;
								flag_tab[i] = FL_VALID;
								call_tab[i] = '0;
								seg_start[i] = '0;
							end
					if (s < 0) r.st = ST_FULL;
					else begin
						ic = (flag_tab[s] & FL_INCALL) != 0;
						run = (flag_tab[s] & FL_RUNNING) != 0;
						if (cmd == CMD_ENTER && num >= CALLS) begin
							flag_tab[s] = FL_VALID;
							call_tab[s] = '0;
							r.st = ST_RANGE;
						end else begin
							if (cmd == CMD_ENTER) begin
								call_tab[s] = num;
								seg_start[s] = now;
								flag_tab[s] = FL_VALID | FL_INCALL | FL_RUNNING;
							end else if (cmd == CMD_SWOUT) begin
								if (ic && run) close_seg(s, now);
							end else if (ic && !run) begin
								seg_start[s] = now;
								flag_tab[s] |= FL_RUNNING;
							end
							fill_report(r, call_tab[s]);
						end
					end
				end
			end
			pending.push_back(r);
		endfunction

		// Compare one report with the oldest prediction
		function void check(energy_report_t got);
			energy_report_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report: st=%0d call=%0d total=%h count=%h",
						got.st, got.call, got.total, got.count);
				return;
			end
			e = pending.pop_front();
			if (got.st !== e.st || got.call !== e.call || got.total !== e.total
					|| got.count !== e.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"report mismatch: exp st=%0d call=%0d total=%h count=%h,",
						" got st=%0d call=%0d total=%h count=%h"},
						e.st, e.call, e.total, e.count,
						got.st, got.call, got.total, got.count);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [CMD_W-1:0] command = '0;
	logic [TID_W-1:0] thread_id = '0;
	logic [NUM_W-1:0] call_number = '0;
	logic [SAMPLE_W-1:0] energy_sample = '0;
	logic done;
	logic [STAT_W-1:0] status;
	logic [TOUCH_W-1:0] touched_call;
	logic [TOTAL_W-1:0] energy_total;
	logic [COUNT_W-1:0] call_count;

	energy_scoreboard sb;
	logic [TID_W-1:0] pool [72];
	logic [SAMPLE_W-1:0] meter;
	bit allow_gaps;

	per_thread_syscall_energy_accumulator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .thread_id(thread_id), .call_number(call_number),
		.energy_sample(energy_sample), .done(done), .status(status),
		.touched_call(touched_call), .energy_total(energy_total), .call_count(call_count)
	);

	always #5 clk = ~clk;

	// Check each report at the edge that ends its strobe cycle
	always @(posedge clk)
		if (arst_n && done === 1'b1 && sb != null)
			sb.check('{status, touched_call, energy_total, call_count});

	// Drive one request, hold it until taken; keep start high if another follows at once
	task automatic send(logic [CMD_W-1:0] cmd, logic [TID_W-1:0] tid,
			logic [NUM_W-1:0] num, logic [SAMPLE_W-1:0] e, bit more);
		int gap;
		start <= 1'b1;
		command <= cmd;
		thread_id <= tid;
		call_number <= num;
		energy_sample <= e;
		do @(posedge clk); while (busy);
		sb.note(cmd, tid, num, e);
		gap = (allow_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (!more || gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [NUM_W-1:0] pick_call();
		int k;
		k = $urandom_range(0, 99);
		if (k < 80) return NUM_W'($urandom_range(0, 15));
		if (k < 86) return NUM_W'(CALLS - 1);
		if (k < 93) return NUM_W'($urandom_range(0, CALLS - 1));
		return NUM_W'($urandom_range(CALLS, (1 << NUM_W) - 1));
	endfunction

	// Random event stream over a thread pool slightly larger than the table
	task automatic random_events(int n, bit last);
		int k;
		logic [CMD_W-1:0] cmd;
		logic [TID_W-1:0] tid;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) allow_gaps = !last && $urandom_range(0, 2) != 0;
			k = $urandom_range(0, 99);
			if (k < 25) cmd = CMD_ENTER;
			else if (k < 40) cmd = CMD_EXIT;
			else if (k < 60) cmd = CMD_SWOUT;
			else if (k < 80) cmd = CMD_SWIN;
			else if (k < 95) cmd = CMD_READ;
			else cmd = CMD_W'($urandom_range(CMD_READ + 1, {CMD_W{1'b1}}));
			tid = ($urandom_range(0, 19) == 0) ? $urandom : pool[$urandom_range(0, 71)];
			if ($urandom_range(0, 15) == 0) meter = SAMPLE_W'({$urandom, $urandom});
			else meter = meter + SAMPLE_W'($urandom_range(0, 1 << 20));
			send(cmd, tid, pick_call(), meter, i != n - 1);
		end
	endtask

	initial begin
		sb = new();
		meter = '0;
		allow_gaps = 1;
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < 72; i++) pool[i] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners
		send(CMD_READ, '0, '0, '0, 1'b1);
		send(CMD_READ, '1, NUM_W'(CALLS - 1), '1, 1'b1);
		send(CMD_READ, '0, '1, '0, 1'b1);
		send({CMD_W{1'b1}}, '0, '0, '0, 1'b1);
		send(CMD_EXIT, 32'h1234, 12'd5, '0, 1'b1);
		send(CMD_ENTER, '0, 12'd5, '0, 1'b1);
		send(CMD_SWOUT, '0, '0, '1, 1'b1);
		send(CMD_SWOUT, '0, '0, 48'h10, 1'b1);
		send(CMD_SWIN, '0, '0, '1, 1'b1);
		send(CMD_SWIN, '0, '0, 48'h5, 1'b1);
		send(CMD_EXIT, '0, '0, 48'h3, 1'b1);
		send(CMD_READ, '0, 12'd5, '0, 1'b1);
		send(CMD_ENTER, '1, '1, 48'h77, 1'b1);
		send(CMD_ENTER, '1, NUM_W'(CALLS - 1), 48'h100, 1'b1);
		send(CMD_ENTER, '1, 12'd7, 48'h200, 1'b1);
		send(CMD_EXIT, '1, '0, 48'h250, 1'b1);
		send(CMD_SWOUT, 32'h1, '0, '0, 1'b1);
		send(CMD_SWIN, 32'h1, '0, '0, 1'b1);
		send(CMD_EXIT, 32'h1, '0, '0, 1'b1);
		send(CMD_READ, '0, 12'd7, '0, 1'b1);
		send(CMD_READ, '0, NUM_W'(CALLS - 1), '0, 1'b0);
		drain();

		// Fill the table past its size, then run random traffic
		for (int i = 0; i < 70; i++)
			send(CMD_SWIN, pool[i], '0, meter, i != 69);
		random_events(900, 1'b0);
		drain();
		random_events(960, 1'b1);

		drain();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire
